/* design/gfr_pkg.sv */
// Shared types and helpers for the formatted UTF-8 glyph framer.
// No dependencies; used by gfr_step, gfr_skid and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gfr_pkg;

	localparam logic [7:0] END_BYTE    = 8'hFF;
	localparam logic [1:0] FMT_PREFIX  = 2'b10;

	// Flag vector positions, bold at the top.
	localparam int FLAG_BOLD      = 6;
	localparam int FLAG_ITALIC    = 5;
	localparam int FLAG_UNDERLINE = 4;
	localparam int FLAG_STRIKE    = 3;
	localparam int FLAG_OVERLINE  = 2;
	localparam int FLAG_SUPER     = 1;
	localparam int FLAG_SUB       = 0;

	typedef struct packed {
		logic       after_format;
		logic [2:0] bytes_remaining;
		logic [3:0] length_so_far;
		logic [6:0] format_flags;
	} gfr_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_glyph;
		logic [3:0] glyph_length;
		logic       end_marker;
		logic       has_format;
		logic [6:0] flags;
	} gfr_res_t;

	// Count of leading ones, 0..8.
	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		casez (b)
			8'b0???_????: n = 4'd0;
			8'b10??_????: n = 4'd1;
			8'b110?_????: n = 4'd2;
			8'b1110_????: n = 4'd3;
			8'b1111_0???: n = 4'd4;
			8'b1111_10??: n = 4'd5;
			8'b1111_110?: n = 4'd6;
			8'b1111_1110: n = 4'd7;
			default:      n = 4'd8;
		endcase
		return n;
	endfunction

	function automatic logic [6:0] decode_format(input logic [7:0] b);
		logic [6:0] f;
		f = '0;
		f[FLAG_BOLD]      = b[5];
		f[FLAG_ITALIC]    = b[4];
		f[FLAG_UNDERLINE] = b[3];
		f[FLAG_STRIKE]    = b[2];
		f[FLAG_OVERLINE]  = b[1] & b[0];
		f[FLAG_SUPER]     = b[1] & ~b[0];
		f[FLAG_SUB]       = b[0] & ~b[1];
		return f;
	endfunction

endpackage

`default_nettype wire

/* design/gfr_step.sv */
// Per-byte framing logic: current state plus one byte in, result word and next state out.
// Depends on gfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfr_step import gfr_pkg::*; (
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	input  wire gfr_state_t cur,
	output gfr_state_t      nxt,
	output gfr_res_t        res
);

	logic [3:0] k;
	logic [3:0] len_inc;
	logic [2:0] rem_dec;

	assign k       = lead_ones(data_byte);
	assign len_inc = cur.length_so_far + 4'd1;
	assign rem_dec = cur.bytes_remaining - 3'd1;

	always_comb begin
		nxt               = cur;
		res.out_byte      = data_byte;
		res.last_of_glyph = 1'b0;
		res.glyph_length  = 4'd0;
		res.end_marker    = 1'b0;
		res.has_format    = cur.after_format;
		res.flags         = cur.format_flags;

		if (end_of_stream) begin
			nxt = '0;
			res = '0;
			res.end_marker = 1'b1;
		end else if (cur.bytes_remaining != 3'd0) begin
			// continuation byte
			if (rem_dec == 3'd0) begin
				nxt = '0;
				res.last_of_glyph = 1'b1;
				res.glyph_length  = len_inc;
			end else begin
				nxt.bytes_remaining = rem_dec;
				nxt.length_so_far   = len_inc;
			end
		end else if (cur.after_format) begin
			// character lead following a format byte
			if (k <= 4'd1) begin
				nxt = '0;
				res.last_of_glyph = 1'b1;
				res.glyph_length  = len_inc;
			end else begin
				nxt.bytes_remaining = 3'(k - 4'd1);
				nxt.length_so_far   = len_inc;
			end
		end else if (data_byte == END_BYTE) begin
			nxt = '0;
			res = '0;
			res.end_marker = 1'b1;
		end else if (!data_byte[7]) begin
			nxt = '0;
			res.last_of_glyph = 1'b1;
			res.glyph_length  = 4'd1;
			res.has_format    = 1'b0;
			res.flags         = '0;
		end else if (data_byte[7:6] == FMT_PREFIX) begin
			nxt.after_format    = 1'b1;
			nxt.bytes_remaining = 3'd0;
			nxt.length_so_far   = 4'd1;
			nxt.format_flags    = decode_format(data_byte);
			res.has_format      = 1'b1;
			res.flags           = decode_format(data_byte);
		end else begin
			nxt.after_format    = 1'b0;
			nxt.bytes_remaining = 3'(k - 4'd1);
			nxt.length_so_far   = 4'd1;
			nxt.format_flags    = '0;
			res.has_format      = 1'b0;
			res.flags           = '0;
		end
	end

endmodule

`default_nettype wire

/* design/gfr_skid.sv */
// Output register with one skid entry; source stall is registered.
// Depends on gfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfr_skid import gfr_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire gfr_res_t push_word,
	output logic          full,
	output logic          dst_valid,
	input  wire logic     dst_stall,
	output gfr_res_t      dst_word
);

	logic     out_valid_q;
	gfr_res_t out_word_q;
	logic     skid_valid_q;
	gfr_res_t skid_word_q;
	logic     pop;

	assign pop       = out_valid_q & ~dst_stall;
	assign full      = skid_valid_q;
	assign dst_valid = out_valid_q;
	assign dst_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_word_q <= skid_word_q;
			end else if (push) begin
				out_word_q <= push_word;
			end
		end else if (push) begin
			skid_word_q <= push_word;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dst_stall && !skid_valid_q && push) |=> skid_valid_q)
		else $error("word pushed under stall was not captured");

endmodule

`default_nettype wire

/* design/formatted_utf8_glyph_framer.sv */
// Formatted UTF-8 glyph framer, top level.
// The glyph state update is a single pass of logic; each accepted byte's result is
// registered in the output or skid register. One byte per cycle unless stalled.
// src_stall rises only when the one-entry skid behind the output register is full.
// Reset (arst_n low, asynchronous): glyph state idle, output and skid empty.
`timescale 1ns / 1ps
`default_nettype none

module formatted_utf8_glyph_framer import gfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// byte channel in
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	// result channel out
	output logic            dst_valid,
	input  wire logic       dst_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_glyph,
	output logic [3:0]      glyph_length,
	output logic            end_marker,
	output logic            has_format,
	output logic            bold,
	output logic            italic,
	output logic            underline,
	output logic            strike,
	output logic            overline,
	output logic            superscript,
	output logic            subscript
);

	// Glyph tracking state: format seen, continuation count, length, flags.
	gfr_state_t state_q;
	gfr_state_t state_nxt;
	gfr_res_t   res;
	gfr_res_t   out_word;
	logic       accept;
	logic       full;

	assign src_stall = full;
	assign accept    = src_valid & ~full;

	gfr_step u_step (
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.cur           (state_q),
		.nxt           (state_nxt),
		.res           (res)
	);

	// State advances only on an accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	gfr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (res),
		.full      (full),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (out_word)
	);

	// Unpack the result word onto the field ports.
	assign out_byte      = out_word.out_byte;
	assign last_of_glyph = out_word.last_of_glyph;
	assign glyph_length  = out_word.glyph_length;
	assign end_marker    = out_word.end_marker;
	assign has_format    = out_word.has_format;
	assign bold          = out_word.flags[FLAG_BOLD];
	assign italic        = out_word.flags[FLAG_ITALIC];
	assign underline     = out_word.flags[FLAG_UNDERLINE];
	assign strike        = out_word.flags[FLAG_STRIKE];
	assign overline      = out_word.flags[FLAG_OVERLINE];
	assign superscript   = out_word.flags[FLAG_SUPER];
	assign subscript     = out_word.flags[FLAG_SUB];

	// A glyph in progress always has at least one byte counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.bytes_remaining != 3'd0) |-> (state_q.length_so_far != 4'd0))
		else $error("continuation pending with zero glyph length");
	// End words carry no length and no last mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && end_marker) |-> (!last_of_glyph && glyph_length == 4'd0))
		else $error("end word carries glyph data");
	// The last byte of a glyph reports a nonzero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && last_of_glyph) |-> (glyph_length != 4'd0))
		else $error("last byte with zero length");
	// End of stream always returns the framer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_stream) |=> (state_q == '0))
		else $error("state not cleared after end of stream");

endmodule

`default_nettype wire
